>>> rtl/core/wksr_pkg.sv
// shared types, constants and key function for the weighted key record sorter
package wksr_pkg;

  localparam int unsigned METRIC_W = 17;
  localparam int unsigned TAG_W    = 16;
  localparam int unsigned KEY_W    = 34;

  localparam logic [KEY_W-1:0] SIM_WEIGHT = KEY_W'(100000);
  localparam logic [KEY_W-1:0] REC_WEIGHT = KEY_W'(100);

  typedef struct packed {
    logic [METRIC_W-1:0] similarity;
    logic [METRIC_W-1:0] recommendation;
    logic [METRIC_W-1:0] inferencing;
    logic [TAG_W-1:0]    tag;
    logic                last;
  } in_t;

  typedef struct packed {
    logic [METRIC_W-1:0] out_similarity;
    logic [METRIC_W-1:0] out_recommendation;
    logic [METRIC_W-1:0] out_inferencing;
    logic [TAG_W-1:0]    out_tag;
    logic                out_last;
    logic                dropped;
  } out_t;

  // one stored record with its ranking key
  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [METRIC_W-1:0] similarity;
    logic [METRIC_W-1:0] recommendation;
    logic [METRIC_W-1:0] inferencing;
    logic [TAG_W-1:0]    tag;
  } rec_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

  // similarity*100000 + recommendation*100 + inferencing, exact in 34 bits
  function automatic logic [KEY_W-1:0] calc_key(input logic [METRIC_W-1:0] s,
                                                input logic [METRIC_W-1:0] r,
                                                input logic [METRIC_W-1:0] i);
    logic [KEY_W-1:0] s_ext;
    logic [KEY_W-1:0] r_ext;
    logic [KEY_W-1:0] i_ext;
    s_ext = KEY_W'(s);
    r_ext = KEY_W'(r);
    i_ext = KEY_W'(i);
    return (s_ext * SIM_WEIGHT) + (r_ext * REC_WEIGHT) + i_ext;
  endfunction

endpackage

>>> rtl/core/wksr_cell.sv
// one cell of the sorted insertion chain
module wksr_cell
  import wksr_pkg::*;
(
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  logic       vld_i,
  input  rec_t       new_rec_i,
  input  rec_t       prev_rec_i,
  input  logic       prev_ins_i,
  input  rec_t       next_rec_i,
  output rec_t       rec_o,
  output logic       ins_o
);

  rec_t rec_q;
  rec_t rec_d;

  // equal keys stay ahead of the newcomer
  assign ins_o = !vld_i || (rec_q.key < new_rec_i.key);
  assign rec_o = rec_q;

  always_comb begin
    rec_d = rec_q;
    if (ctrl_i.insert && ins_o) begin
      rec_d = prev_ins_i ? prev_rec_i : new_rec_i;
    end else if (ctrl_i.shift) begin
      rec_d = next_rec_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

endmodule

>>> rtl/core/weighted_key_record_sorter.sv
// top level of the weighted key record sorter: input stage, cell chain, output register
//
// Records come in on the input channel (in_valid_i / in_stall_o, payload in_data_i).
// The ranking key similarity*100000 + recommendation*100 + inferencing is formed
// as the record is registered and the record is inserted into the cell chain in
// the next cycle, so one record per cycle is taken while a set is loading.
// The chain keeps records in descending key order, equal keys in arrival order.
// Up to MAX_RECORDS records are kept; later ones are discarded and every result
// of that set carries dropped = 1.
// A record with last = 1 closes the set: the input stalls from that transaction
// until the final result has been loaded into the output register. The chain
// then shifts toward cell 0 one record per cycle; the first result is loaded
// into the output register once the last record has passed the input stage into
// the chain, and results follow one per cycle while out_stall_i is low. A stalled
// result holds in the output register and the chain waits. out_last marks the
// final result, after which the block is empty. Reset clears the fill count, the
// overflow flag and all valid state; stored record contents are not cleared.
module weighted_key_record_sorter
  import wksr_pkg::*;
#(
  parameter int unsigned MAX_RECORDS = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int unsigned FILL_W = $clog2(MAX_RECORDS + 1);

  logic              stg_vld_q, stg_vld_d;
  logic              stg_last_q;
  rec_t              stg_rec_q;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              ovf_q, ovf_d;
  logic              drain_q, drain_d;
  logic              out_vld_q, out_vld_d;
  out_t              out_q;

  logic       in_accept;
  logic       not_full;
  logic       take;
  cell_ctrl_t ctrl;

  rec_t cell_rec [MAX_RECORDS];
  logic cell_ins [MAX_RECORDS];

  assign in_stall_o = drain_q || (stg_vld_q && stg_last_q);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign not_full   = fill_q < FILL_W'(MAX_RECORDS);
  assign take       = drain_q && (!out_vld_q || !out_stall_i);

  assign ctrl.insert = stg_vld_q && not_full;
  assign ctrl.shift  = take;

  // input stage: register the record together with its key
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      stg_rec_q.key            <= calc_key(in_data_i.similarity,
                                           in_data_i.recommendation,
                                           in_data_i.inferencing);
      stg_rec_q.similarity     <= in_data_i.similarity;
      stg_rec_q.recommendation <= in_data_i.recommendation;
      stg_rec_q.inferencing    <= in_data_i.inferencing;
      stg_rec_q.tag            <= in_data_i.tag;
      stg_last_q               <= in_data_i.last;
    end
  end

  for (genvar g = 0; g < MAX_RECORDS; g++) begin : g_cell
    rec_t prev_rec;
    logic prev_ins;
    rec_t next_rec;

    if (g == 0) begin : g_head
      assign prev_rec = stg_rec_q;
      assign prev_ins = 1'b0;
    end else begin : g_body
      assign prev_rec = cell_rec[g-1];
      assign prev_ins = cell_ins[g-1];
    end

    if (g == MAX_RECORDS - 1) begin : g_tail
      assign next_rec = cell_rec[g];
    end else begin : g_mid
      assign next_rec = cell_rec[g+1];
    end

    wksr_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .vld_i      (FILL_W'(g) < fill_q),
      .new_rec_i  (stg_rec_q),
      .prev_rec_i (prev_rec),
      .prev_ins_i (prev_ins),
      .next_rec_i (next_rec),
      .rec_o      (cell_rec[g]),
      .ins_o      (cell_ins[g])
    );
  end

  always_comb begin
    stg_vld_d = in_accept;
    fill_d    = fill_q;
    ovf_d     = ovf_q;
    drain_d   = drain_q;
    if (stg_vld_q) begin
      if (not_full) begin
        fill_d = fill_q + FILL_W'(1);
      end else begin
        ovf_d = 1'b1;
      end
      if (stg_last_q) begin
        drain_d = 1'b1;
      end
    end
    if (take) begin
      fill_d = fill_q - FILL_W'(1);
      if (fill_q == FILL_W'(1)) begin
        drain_d = 1'b0;
        ovf_d   = 1'b0;
      end
    end
    out_vld_d = take || (out_vld_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= 1'b0;
      fill_q    <= '0;
      ovf_q     <= 1'b0;
      drain_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      stg_vld_q <= stg_vld_d;
      fill_q    <= fill_d;
      ovf_q     <= ovf_d;
      drain_q   <= drain_d;
      out_vld_q <= out_vld_d;
    end
  end

  // output register fed from the head of the chain
  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q.out_similarity     <= cell_rec[0].similarity;
      out_q.out_recommendation <= cell_rec[0].recommendation;
      out_q.out_inferencing    <= cell_rec[0].inferencing;
      out_q.out_tag            <= cell_rec[0].tag;
      out_q.out_last           <= (fill_q == FILL_W'(1));
      out_q.dropped            <= ovf_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/core/wksr_checker.sv
// port-level checks for the weighted key record sorter, bound to the top level
module wksr_checker
  import wksr_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input in_t  in_data_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // a closing record blocks further input
  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.last |=> in_stall_o)
    else $error("input not stalled after closing record");

  // no input while a run is still draining
  a_drain_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.out_last |-> in_stall_o)
    else $error("input open during sorted run");

  // results of one run come back to back with a constant dropped flag
  a_run_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.out_last |=>
      out_valid_o && (out_data_o.dropped == $past(out_data_o.dropped)))
    else $error("sorted run broken or dropped flag changed");

endmodule

bind weighted_key_record_sorter wksr_checker u_wksr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

>>> tb/testbench.sv
// self-checking testbench for the weighted key record sorter
module testbench;
  import wksr_pkg::*;

  localparam int unsigned STORE_DEPTH  = 64;
  localparam int unsigned RANDOM_ITEMS = 8;
  localparam int unsigned HOLD_CYCLES  = 250;
  localparam int unsigned DRAIN_LIMIT  = 20000;
  localparam int unsigned TAIL_CYCLES  = 10;
  localparam longint unsigned SIM_SCALE = 100000;
  localparam longint unsigned REC_SCALE = 100;

  typedef struct {
    logic [KEY_W-1:0] rank;
    in_t              rec;
  } ranked_rec_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  // model of the sorter contents and the results still owed
  ranked_rec_t ranked_store[$];
  bit          store_overflow;
  out_t        sorted_due[$];

  int unsigned mismatch_count = 0;
  int unsigned items_sent = 0;
  bit          quiet = 1'b0;
  int unsigned hold_req = 0;

  weighted_key_record_sorter #(
    .MAX_RECORDS(STORE_DEPTH)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (mismatch_count < 100) begin
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
    end
    mismatch_count++;
  endtask

  function automatic logic [KEY_W-1:0] rank_of(input in_t rec);
    longint unsigned acc;
    acc = 64'(rec.similarity) * SIM_SCALE + 64'(rec.recommendation) * REC_SCALE
        + 64'(rec.inferencing);
    return acc[KEY_W-1:0];
  endfunction

  // insert behind every stored record of greater or equal rank, flush on last
  task automatic rank_insert(input in_t rec);
    ranked_rec_t entry;
    int          pos;
    out_t        res;
    if (ranked_store.size() >= STORE_DEPTH) begin
      store_overflow = 1'b1;
    end else begin
      entry.rank = rank_of(rec);
      entry.rec  = rec;
      pos = ranked_store.size();
      while (pos > 0 && ranked_store[pos-1].rank < entry.rank) pos--;
      ranked_store.insert(pos, entry);
    end
    if (rec.last) begin
      foreach (ranked_store[k]) begin
        res.out_similarity     = ranked_store[k].rec.similarity;
        res.out_recommendation = ranked_store[k].rec.recommendation;
        res.out_inferencing    = ranked_store[k].rec.inferencing;
        res.out_tag            = ranked_store[k].rec.tag;
        res.out_last           = (k == ranked_store.size() - 1);
        res.dropped            = store_overflow;
        sorted_due.push_back(res);
      end
      ranked_store.delete();
      store_overflow = 1'b0;
    end
  endtask

  function automatic in_t make_rec(input logic [METRIC_W-1:0] s, input logic [METRIC_W-1:0] r,
                                   input logic [METRIC_W-1:0] i, input logic [TAG_W-1:0] t,
                                   input logic last);
    in_t rec;
    rec.similarity     = s;
    rec.recommendation = r;
    rec.inferencing    = i;
    rec.tag            = t;
    rec.last           = last;
    return rec;
  endfunction

  function automatic logic [METRIC_W-1:0] rand_metric();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 6) return METRIC_W'($urandom_range(65536));
    // coarse values give many equal keys
    if (pick < 8) return METRIC_W'($urandom_range(4) * 16384);
    return METRIC_W'($urandom);
  endfunction

  function automatic in_t rand_rec(input logic last);
    return make_rec(rand_metric(), rand_metric(), rand_metric(), TAG_W'($urandom), last);
  endfunction

  // one record transaction; valid stays up afterwards for a following record
  task automatic send_record(input in_t rec);
    while (!quiet && $urandom_range(99) < 8) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= rec;
    do @(posedge clk_i); while (in_stall_o);
    rank_insert(rec);
    items_sent++;
  endtask

  task automatic send_set(input int unsigned count);
    for (int unsigned n = 1; n <= count; n++) send_record(rand_rec(n == count));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sorted_due.size() != 0);
  endtask

  task automatic test_single_record();
    send_record(make_rec('1, '1, '1, '1, 1'b1));
  endtask

  task automatic test_extremes_and_ties();
    send_record(make_rec(17'd0, 17'd0, 17'd0, 16'h0000, 1'b0));
    send_record(make_rec(17'd65536, 17'd65536, 17'd65536, 16'hFFFF, 1'b0));
    send_record(make_rec(17'h1FFFF, 17'd0, 17'd0, 16'h1234, 1'b0));
    send_record(make_rec(17'd0, 17'h1FFFF, 17'h1FFFF, 16'h00FF, 1'b0));
    // three different records with the same key, arrival order must hold
    send_record(make_rec(17'd1, 17'd0, 17'd0, 16'hA001, 1'b0));
    send_record(make_rec(17'd0, 17'd1000, 17'd0, 16'hA002, 1'b0));
    send_record(make_rec(17'd0, 17'd999, 17'd100, 16'hA003, 1'b0));
    send_record(make_rec(17'd0, 17'd0, 17'd0, 16'hA004, 1'b0));
    send_record(make_rec(17'd0, 17'd0, 17'd1, 16'hA005, 1'b0));
    send_record(make_rec(17'd65536, 17'd65536, 17'd65536, 16'h5555, 1'b0));
    send_record(make_rec(17'h0AAAA, 17'h15555, 17'h0AAAA, 16'hAAAA, 1'b0));
    send_record(make_rec(17'h15555, 17'h0AAAA, 17'h15555, 16'h5555, 1'b1));
  endtask

  // fill the store, then the extra and the last record are dropped
  task automatic test_full_store();
    send_set(STORE_DEPTH + 2);
  endtask

  // output held while a second set is offered, so the input has to stall
  task automatic test_backpressure();
    hold_req = HOLD_CYCLES;
    send_set(10);
    send_set(6);
  endtask

  task automatic test_drain_pause();
    send_set(6);
    wait_drained();
    send_set(5);
    wait_drained();
  endtask

  task automatic test_no_idle();
    quiet = 1'b1;
    for (int unsigned n = 1; n <= 5; n++) send_set(n);
    wait_drained();
    quiet = 1'b0;
  endtask

  task automatic test_random_sets();
    int unsigned stop_at;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      send_set($urandom_range(1, 6));
    end
  endtask

  // receiver side: random stalls, or a counted hold-off on request
  initial begin : out_stall_gen
    int unsigned hold_left;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !quiet && ($urandom_range(99) < 8);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (sorted_due.size() == 0) begin
        report_mismatch("result with none pending, tag", out_data_o.out_tag, 0);
      end else begin
        want = sorted_due.pop_front();
        if (out_data_o.out_similarity !== want.out_similarity)
          report_mismatch("out_similarity", out_data_o.out_similarity, want.out_similarity);
        if (out_data_o.out_recommendation !== want.out_recommendation)
          report_mismatch("out_recommendation", out_data_o.out_recommendation,
                          want.out_recommendation);
        if (out_data_o.out_inferencing !== want.out_inferencing)
          report_mismatch("out_inferencing", out_data_o.out_inferencing, want.out_inferencing);
        if (out_data_o.out_tag !== want.out_tag)
          report_mismatch("out_tag", out_data_o.out_tag, want.out_tag);
        if (out_data_o.out_last !== want.out_last)
          report_mismatch("out_last", out_data_o.out_last, want.out_last);
        if (out_data_o.dropped !== want.dropped)
          report_mismatch("dropped", out_data_o.dropped, want.dropped);
      end
    end
  end

  initial begin
    #1000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : main_seq
    int unsigned waited;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    store_overflow = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_record();
    test_extremes_and_ties();
    test_full_store();
    test_backpressure();
    test_drain_pause();
    test_no_idle();
    test_random_sets();

    in_valid_i <= 1'b0;
    waited = 0;
    while (sorted_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sorted_due.size() != 0) report_mismatch("results never seen", sorted_due.size(), 0);

    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
